### rtl/assert_macros.svh
// Assertion macros shared by the placer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define GWP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("placer assertion failed");
// cond must never be seen out of reset
`define GWP_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("placer forbidden condition seen");
`else
`define GWP_ASSERT(lbl, clk, rst_n, prop)
`define GWP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/gwp_pkg.sv
// Types, constants and helpers of the word-wrap placer.
`default_nettype none
package gwp_pkg;
	localparam int WORD_DEPTH = 32;
	localparam int CNT_W      = $clog2(WORD_DEPTH + 1);
	localparam int ADDR_W     = $clog2(WORD_DEPTH);
	localparam int GLYPH_W    = 16;
	localparam int ADV_W      = 12;
	localparam int POS_W      = 22;
	localparam int LINE_W     = 10;
	localparam int WIDTH_W    = 18;
	localparam int ENTRY_W    = GLYPH_W + POS_W;

	localparam logic [POS_W-1:0]   POS_MAX          = '1;
	localparam logic [LINE_W-1:0]  LINE_MAX         = '1;
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = '1;

	typedef enum logic [1:0] {
		KIND_GLYPH   = 2'd0,
		KIND_SPACE   = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_WRAP_ENABLE = 1'b0,
		CFG_LINE_WIDTH  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLACE_A,
		ST_PLACE_B,
		ST_REPLAY,
		ST_WORD_END,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [GLYPH_W-1:0] glyph;
		logic [ADV_W-1:0]   adv;
		logic               vis;
	} cmd_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [LINE_W-1:0]  line;
		logic [POS_W-1:0]   x;
		logic               done;
		logic               ovf;
		logic               last;
	} res_t;

	function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W+1:0] v);
		return (v > {2'b00, POS_MAX}) ? POS_MAX : v[POS_W-1:0];
	endfunction

	function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
		return (l == LINE_MAX) ? l : l + 1'b1;
	endfunction
endpackage
`default_nettype wire

### rtl/gwp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gwp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/gwp_front.sv
// Front end: input handshake, character classification and command queue.
`default_nettype none
`include "assert_macros.svh"
module gwp_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [1:0]              char_kind,
	input  wire logic [15:0]             glyph_code,
	input  wire logic [11:0]             advance,
	input  wire logic                    visible,
	output logic                         cmd_valid,
	input  wire logic                    cmd_pop,
	output gwp_pkg::cmd_t                cmd
);
	import gwp_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push;
	logic       do_pop;

	// only ordinary glyphs are marked visible; other kinds never place a glyph
	always_comb begin
		cls.kind  = kind_t'(char_kind);
		cls.glyph = glyph_code;
		cls.adv   = advance;
		cls.vis   = visible && (kind_t'(char_kind) == KIND_GLYPH);
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	`GWP_NEVER(a_front_pop_empty, clk, arst_n, cmd_pop && !cmd_valid)
endmodule
`default_nettype wire

### rtl/gwp_resq.sv
// Result queue: two entries between the placer engine and the output ports.
`default_nettype none
`include "assert_macros.svh"
module gwp_resq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_push,
	input  wire gwp_pkg::res_t res_in,
	output logic               res_full,
	input  wire logic          pop,
	output logic               empty,
	output gwp_pkg::res_t      res_out
);
	import gwp_pkg::*;

	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign res_out  = ent_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	`GWP_NEVER(a_resq_overfill, clk, arst_n, res_push && res_full)
endmodule
`default_nettype wire

### rtl/gwp_back.sv
// Back end: word buffering, line placement and glyph replay sequencer.
`default_nettype none
`include "assert_macros.svh"
module gwp_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wrap_enable,
	input  wire logic [gwp_pkg::WIDTH_W-1:0]    line_width,
	input  wire logic                           cmd_valid,
	output logic                                cmd_pop,
	input  wire gwp_pkg::cmd_t                  cmd,
	output logic                                ram_we,
	output logic [gwp_pkg::ADDR_W-1:0]          ram_waddr,
	output logic [gwp_pkg::ENTRY_W-1:0]         ram_wdata,
	output logic                                ram_re,
	output logic [gwp_pkg::ADDR_W-1:0]          ram_raddr,
	input  wire logic [gwp_pkg::ENTRY_W-1:0]    ram_rdata,
	output logic                                res_push,
	output gwp_pkg::res_t                       res,
	input  wire logic                           res_full
);
	import gwp_pkg::*;

	state_t             state_q, state_n;
	cmd_t               cmd_q, cmd_n;
	logic [POS_W-1:0]   ll_q, ll_n;
	logic [POS_W-1:0]   ps_q, ps_n;
	logic [POS_W-1:0]   wl_q, wl_n;
	logic [LINE_W-1:0]  cl_q, cl_n;
	logic               used_q, used_n;
	logic               open_q, open_n;
	logic               ovf_q, ovf_n;
	logic               pov_q, pov_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [CNT_W-1:0]   idx_q, idx_n;
	logic [POS_W:0]     sum_s1, sum_n;
	logic [POS_W-1:0]   x0_q, x0_n;
	logic               close_q, close_n;

	logic [POS_W+1:0]   need;
	logic [GLYPH_W-1:0] rd_glyph;
	logic [POS_W-1:0]   rd_off;
	logic [CNT_W-1:0]   idx_inc;
	logic [LINE_W-1:0]  total;

	assign need     = {1'b0, sum_s1} + {2'b00, wl_q};
	assign rd_glyph = ram_rdata[ENTRY_W-1 -: GLYPH_W];
	assign rd_off   = ram_rdata[POS_W-1:0];
	assign idx_inc  = idx_q + 1'b1;
	assign total    = (cl_q == LINE_MAX) ? cl_q : cl_q + {{(LINE_W-1){1'b0}}, used_q};

	always_comb begin
		state_n = state_q;
		cmd_n   = cmd_q;
		ll_n    = ll_q;
		ps_n    = ps_q;
		wl_n    = wl_q;
		cl_n    = cl_q;
		used_n  = used_q;
		open_n  = open_q;
		ovf_n   = ovf_q;
		pov_n   = pov_q;
		cnt_n   = cnt_q;
		idx_n   = idx_q;
		sum_n   = sum_s1;
		x0_n    = x0_q;
		close_n = close_q;

		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = {cmd.glyph, wl_q};
		ram_re    = 1'b0;
		ram_raddr = idx_q[ADDR_W-1:0];
		res_push  = 1'b0;
		res       = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (!wrap_enable) begin
						// single line: glyphs go straight out at the pen
						if (cmd.kind == KIND_END) begin
							res.line = {{(LINE_W-1){1'b0}}, 1'b1};
							res.done = 1'b1;
							res.last = 1'b1;
							if (!res_full) begin
								res_push = 1'b1;
								cmd_pop  = 1'b1;
								ps_n     = '0;
								ll_n     = '0;
								cl_n     = '0;
								used_n   = 1'b0;
								wl_n     = '0;
								cnt_n    = '0;
								ovf_n    = 1'b0;
								open_n   = 1'b0;
							end
						end else begin
							res.glyph = cmd.glyph;
							res.x     = ll_q;
							res.last  = 1'b1;
							if (!(cmd.vis && res_full)) begin
								res_push = cmd.vis;
								cmd_pop  = 1'b1;
								ll_n     = sat_pos({2'b00, ll_q} + {12'd0, cmd.adv});
							end
						end
					end else if (cmd.kind == KIND_GLYPH) begin
						cmd_pop = 1'b1;
						if (cmd.vis) begin
							if (cnt_q < CNT_W'(WORD_DEPTH)) begin
								ram_we = 1'b1;
								cnt_n  = cnt_q + 1'b1;
							end else begin
								ovf_n = 1'b1;
							end
						end
						wl_n   = sat_pos({2'b00, wl_q} + {12'd0, cmd.adv});
						open_n = 1'b1;
					end else begin
						cmd_pop = 1'b1;
						cmd_n   = cmd;
						pov_n   = 1'b0;
						state_n = open_q ? ST_PLACE_A : ST_FINISH;
					end
				end
			end
			ST_PLACE_A: begin
				sum_n   = {1'b0, ll_q} + {1'b0, ps_q};
				state_n = ST_PLACE_B;
			end
			ST_PLACE_B: begin
				close_n = 1'b0;
				x0_n    = '0;
				if (used_q && (need <= {6'd0, line_width})) begin
					x0_n = sat_pos({1'b0, sum_s1});
					ll_n = sat_pos(need);
				end else begin
					if (used_q) begin
						cl_n   = line_inc(cl_q);
						used_n = 1'b0;
						ll_n   = '0;
					end
					// word alone on its line; too long means it closes the line
					if (wl_q > {4'd0, line_width}) begin
						close_n = 1'b1;
					end else begin
						ll_n   = wl_q;
						used_n = 1'b1;
					end
				end
				idx_n = '0;
				if (cnt_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_n   = ST_REPLAY;
				end else begin
					state_n = ST_WORD_END;
				end
			end
			ST_REPLAY: begin
				res.glyph = rd_glyph;
				res.line  = cl_q;
				res.x     = sat_pos({2'b00, x0_q} + {2'b00, rd_off});
				res.ovf   = ovf_q;
				res.last  = (idx_inc == cnt_q) && (cmd_q.kind != KIND_END);
				if (!res_full) begin
					res_push = 1'b1;
					if (idx_inc == cnt_q) begin
						state_n = ST_WORD_END;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_inc[ADDR_W-1:0];
						idx_n     = idx_inc;
					end
				end
			end
			ST_WORD_END: begin
				if (close_q) begin
					cl_n   = line_inc(cl_q);
					used_n = 1'b0;
					ll_n   = '0;
				end
				pov_n   = ovf_q;
				ps_n    = '0;
				cnt_n   = '0;
				wl_n    = '0;
				ovf_n   = 1'b0;
				open_n  = 1'b0;
				state_n = ST_FINISH;
			end
			ST_FINISH: begin
				case (cmd_q.kind)
					KIND_SPACE: begin
						ps_n    = sat_pos({2'b00, ps_q} + {12'd0, cmd_q.adv});
						state_n = ST_IDLE;
					end
					KIND_NEWLINE: begin
						cl_n    = line_inc(cl_q);
						used_n  = 1'b0;
						ll_n    = '0;
						ps_n    = '0;
						state_n = ST_IDLE;
					end
					default: begin
						// end of text: line total, then back to a fresh text
						res.line = total;
						res.done = 1'b1;
						res.ovf  = pov_q;
						res.last = 1'b1;
						if (!res_full) begin
							res_push = 1'b1;
							ps_n     = '0;
							ll_n     = '0;
							cl_n     = '0;
							used_n   = 1'b0;
							wl_n     = '0;
							cnt_n    = '0;
							ovf_n    = 1'b0;
							open_n   = 1'b0;
							state_n  = ST_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_n;
		sum_s1 <= sum_n;
		x0_q   <= x0_n;
		idx_q  <= idx_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ll_q    <= '0;
			ps_q    <= '0;
			wl_q    <= '0;
			cl_q    <= '0;
			used_q  <= 1'b0;
			open_q  <= 1'b0;
			ovf_q   <= 1'b0;
			pov_q   <= 1'b0;
			cnt_q   <= '0;
			close_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ll_q    <= ll_n;
			ps_q    <= ps_n;
			wl_q    <= wl_n;
			cl_q    <= cl_n;
			used_q  <= used_n;
			open_q  <= open_n;
			ovf_q   <= ovf_n;
			pov_q   <= pov_n;
			cnt_q   <= cnt_n;
			close_q <= close_n;
		end
	end

	`GWP_ASSERT(a_back_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(WORD_DEPTH))
	`GWP_NEVER(a_back_replay_idx, clk, arst_n, (state_q == ST_REPLAY) && (idx_q >= cnt_q))
	`GWP_NEVER(a_back_ovf_no_word, clk, arst_n, ovf_q && !open_q)
endmodule
`default_nettype wire

### rtl/greedy_word_wrap_placer.sv
// Top level of the greedy word-wrap glyph placer.
//
// Input channel: one decoded character per request (char_kind, glyph_code,
// advance, visible), taken at a clock edge with push high and full low. A
// two-entry command queue sits behind the input, so requests are taken while
// the engine is busy replaying a word.
// Result channel: placed glyphs (out_glyph, line_index, x_pos) and one
// end-of-text summary (text_done, line total in line_index). The oldest
// result is shown while empty is low and leaves on pop. last marks the final
// result a request caused; word_overflow flags words longer than the buffer.
// Timing: in wrap mode a glyph is buffered from the idle state; a space,
// newline or end of text closing a word passes through PLACE_A, PLACE_B,
// REPLAY (if glyphs are buffered; they are read back one at a time through
// the single read port of the word buffer), WORD_END and FINISH, and with no
// open word straight to FINISH. In single-line mode a result enters the
// result queue at the edge its request leaves the command queue; a word's
// first glyph enters from REPLAY, after PLACE_A and PLACE_B.
// A full result queue stalls the engine; the command queue then fills and
// full rises. Reset empties both queues, clears all text state and loads
// wrap_enable = 0, line_width = all ones. Configure only while idle.
`default_nettype none
module greedy_word_wrap_placer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [17:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  char_kind,
	input  wire logic [15:0] glyph_code,
	input  wire logic [11:0] advance,
	input  wire logic        visible,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      out_glyph,
	output logic [9:0]       line_index,
	output logic [21:0]      x_pos,
	output logic             text_done,
	output logic             word_overflow,
	output logic             last
);
	import gwp_pkg::*;

	logic               wrap_q;
	logic [WIDTH_W-1:0] lwidth_q;
	cmd_t               cmd;
	logic               cmd_valid;
	logic               cmd_pop;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               res_push;
	logic               res_full;
	res_t               res_in;
	res_t               res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q   <= 1'b0;
			lwidth_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WRAP_ENABLE: wrap_q   <= cfg_data[0];
				CFG_LINE_WIDTH:  lwidth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gwp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_kind  (char_kind),
		.glyph_code (glyph_code),
		.advance    (advance),
		.visible    (visible),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	// word buffer: glyph code and x offset inside the word
	gwp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WORD_DEPTH)
	) u_word_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gwp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wrap_enable (wrap_q),
		.line_width  (lwidth_q),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.res_push    (res_push),
		.res         (res_in),
		.res_full    (res_full)
	);

	gwp_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign out_glyph     = res_out.glyph;
	assign line_index    = res_out.line;
	assign x_pos         = res_out.x;
	assign text_done     = res_out.done;
	assign word_overflow = res_out.ovf;
	assign last          = res_out.last;
endmodule
`default_nettype wire

### tb/sv/placement_checker.sv
// Scoreboard for the word-wrap placer: predicts every placement and checks each popped result.
module placement_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [gwp_pkg::WIDTH_W-1:0]   cfg_data,
	input  wire logic                          push,
	input  wire logic                          full,
	input  wire logic [1:0]                    char_kind,
	input  wire logic [gwp_pkg::GLYPH_W-1:0]   glyph_code,
	input  wire logic [gwp_pkg::ADV_W-1:0]     advance,
	input  wire logic                          visible,
	input  wire logic                          empty,
	input  wire logic                          pop,
	input  wire logic [gwp_pkg::GLYPH_W-1:0]   out_glyph,
	input  wire logic [gwp_pkg::LINE_W-1:0]    line_index,
	input  wire logic [gwp_pkg::POS_W-1:0]     x_pos,
	input  wire logic                          text_done,
	input  wire logic                          word_overflow,
	input  wire logic                          last,
	output int                                 fail_count,
	output int                                 outstanding,
	output int                                 results_checked,
	output int                                 texts_closed,
	output int                                 overflow_hits
);
	import gwp_pkg::*;

	// settings as the block holds them
	logic               wrap_q;
	logic [WIDTH_W-1:0] width_q;

	// text state of the placer
	logic [GLYPH_W-1:0] buf_glyph [WORD_DEPTH];
	logic [POS_W-1:0]   buf_off   [WORD_DEPTH];
	logic [CNT_W-1:0]   word_cnt;
	logic [POS_W-1:0]   word_len;
	logic [POS_W-1:0]   space_run;
	logic [POS_W-1:0]   line_len;
	logic [LINE_W-1:0]  cur_line;
	logic               word_ovf;
	logic               word_open;
	logic               line_used;

	res_t expected_placements [$];

	int errors    = 0;
	int n_checked = 0;
	int n_texts   = 0;
	int n_ovf     = 0;

	function automatic logic [POS_W-1:0] clip_pos(input logic [POS_W+1:0] v);
		if (v > {2'b00, POS_MAX})
			return POS_MAX;
		return v[POS_W-1:0];
	endfunction

	task automatic queue_placement(input logic [GLYPH_W-1:0] g, input logic [LINE_W-1:0] ln,
			input logic [POS_W-1:0] x, input logic done, input logic ovf);
		res_t r;
		r.glyph = g;
		r.line  = ln;
		r.x     = x;
		r.done  = done;
		r.ovf   = ovf;
		r.last  = 1'b0;
		expected_placements.push_back(r);
	endtask

	task automatic open_new_line();
		if (cur_line != LINE_MAX)
			cur_line = cur_line + 1'b1;
		line_used = 1'b0;
		line_len  = '0;
	endtask

	task automatic drop_word();
		word_cnt  = '0;
		word_len  = '0;
		word_ovf  = 1'b0;
		word_open = 1'b0;
	endtask

	task automatic drop_text();
		drop_word();
		space_run = '0;
		line_len  = '0;
		cur_line  = '0;
		line_used = 1'b0;
	endtask

	// Puts the open word on a line; hands back the word's overflow flag.
	task automatic settle_word(output logic ovf);
		logic [POS_W+1:0] need;
		logic [POS_W-1:0] x0;
		logic             close_after;
		ovf = 1'b0;
		x0 = '0;
		close_after = 1'b0;
		if (word_open) begin
			ovf = word_ovf;
			if (line_used) begin
				need = {2'b00, line_len} + {2'b00, space_run} + {2'b00, word_len};
				if (need <= {6'b0, width_q}) begin
					x0 = clip_pos({2'b00, line_len} + {2'b00, space_run});
					line_len = clip_pos(need);
				end else begin
					open_new_line();
				end
			end
			if (!line_used) begin
				x0 = '0;
				if (word_len > {4'b0, width_q}) begin
					close_after = 1'b1;
				end else begin
					line_len  = word_len;
					line_used = 1'b1;
				end
			end
			for (int i = 0; i < int'(word_cnt); i++)
				queue_placement(buf_glyph[i], cur_line,
					clip_pos({2'b00, x0} + {2'b00, buf_off[i]}), 1'b0, ovf);
			if (close_after)
				open_new_line();
			space_run = '0;
			drop_word();
		end
	endtask

	task automatic predict_char(input kind_t kind, input logic [GLYPH_W-1:0] g,
			input logic [ADV_W-1:0] adv, input logic vis);
		int               before_n;
		logic             ovf;
		logic [LINE_W:0]  total;
		res_t             r;
		before_n = expected_placements.size();
		if (!wrap_q) begin
			// single line: glyphs leave at once at the running pen
			if (kind == KIND_END) begin
				queue_placement('0, LINE_W'(1), '0, 1'b1, 1'b0);
				drop_text();
			end else begin
				if (kind == KIND_GLYPH && vis)
					queue_placement(g, '0, line_len, 1'b0, 1'b0);
				line_len = clip_pos({2'b00, line_len} + {12'b0, adv});
			end
		end else begin
			case (kind)
				KIND_GLYPH: begin
					if (vis) begin
						if (int'(word_cnt) < WORD_DEPTH) begin
							buf_glyph[word_cnt[ADDR_W-1:0]] = g;
							buf_off[word_cnt[ADDR_W-1:0]]   = word_len;
							word_cnt = word_cnt + 1'b1;
						end else begin
							word_ovf = 1'b1;
						end
					end
					word_len  = clip_pos({2'b00, word_len} + {12'b0, adv});
					word_open = 1'b1;
				end
				KIND_SPACE: begin
					settle_word(ovf);
					space_run = clip_pos({2'b00, space_run} + {12'b0, adv});
				end
				KIND_NEWLINE: begin
					settle_word(ovf);
					open_new_line();
					space_run = '0;
				end
				default: begin
					settle_word(ovf);
					total = {1'b0, cur_line} + {{LINE_W{1'b0}}, line_used};
					if (total > {1'b0, LINE_MAX})
						total = {1'b0, LINE_MAX};
					queue_placement('0, total[LINE_W-1:0], '0, 1'b1, ovf);
					drop_text();
				end
			endcase
		end
		if (expected_placements.size() > before_n) begin
			r = expected_placements.pop_back();
			r.last = 1'b1;
			expected_placements.push_back(r);
		end
	endtask

	task automatic check_result();
		res_t want;
		if (expected_placements.size() == 0) begin
			$error("result with nothing expected: glyph %0h line %0d x %0d done %0b",
				out_glyph, line_index, x_pos, text_done);
			errors++;
		end else begin
			want = expected_placements.pop_front();
			n_checked++;
			if (out_glyph !== want.glyph) begin
				$error("out_glyph: expected %0h, actual %0h", want.glyph, out_glyph);
				errors++;
			end
			if (line_index !== want.line) begin
				$error("line_index: expected %0d, actual %0d", want.line, line_index);
				errors++;
			end
			if (x_pos !== want.x) begin
				$error("x_pos: expected %0d, actual %0d", want.x, x_pos);
				errors++;
			end
			if (text_done !== want.done) begin
				$error("text_done: expected %0b, actual %0b", want.done, text_done);
				errors++;
			end
			if (word_overflow !== want.ovf) begin
				$error("word_overflow: expected %0b, actual %0b", want.ovf, word_overflow);
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, last);
				errors++;
			end
			if (want.done)
				n_texts++;
			if (want.ovf)
				n_ovf++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q  = 1'b0;
			width_q = LINE_WIDTH_RESET;
			drop_text();
			expected_placements.delete();
		end else begin
			// pop first: a result never comes from a request taken at the same edge
			if (pop && !empty)
				check_result();
			if (cfg_we) begin
				if (cfg_idx_t'(cfg_index) == CFG_WRAP_ENABLE)
					wrap_q = cfg_data[0];
				else
					width_q = cfg_data;
			end
			if (push && !full)
				predict_char(kind_t'(char_kind), glyph_code, advance, visible);
		end
		fail_count      <= errors;
		outstanding     <= expected_placements.size();
		results_checked <= n_checked;
		texts_closed    <= n_texts;
		overflow_hits   <= n_ovf;
	end

endmodule

### tb/sv/tb_greedy_word_wrap_placer.sv
// Testbench top for the greedy word-wrap placer: stimulus, idling and verdict.
module tb_greedy_word_wrap_placer;
	import gwp_pkg::*;

	// cycles the engine may still need after the last expected result
	// (a word end steps through PLACE_A, PLACE_B, REPLAY, WORD_END and FINISH)
	localparam int SETTLE_CYCLES = 2 * WORD_DEPTH + 16;
	localparam int RANDOM_ITEMS  = 192;
	localparam int RANDOM_PHASES = 6;
	localparam int DRAIN_LIMIT   = 200000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// configuration port
	logic               cfg_we    = 1'b0;
	cfg_idx_t           cfg_index = CFG_WRAP_ENABLE;
	logic [WIDTH_W-1:0] cfg_data  = '0;

	// request side
	logic               push       = 1'b0;
	logic               full;
	kind_t              char_kind  = KIND_GLYPH;
	logic [GLYPH_W-1:0] glyph_code = '0;
	logic [ADV_W-1:0]   advance    = '0;
	logic               visible    = 1'b0;

	// result side
	logic               empty;
	logic               pop = 1'b0;
	logic [GLYPH_W-1:0] out_glyph;
	logic [LINE_W-1:0]  line_index;
	logic [POS_W-1:0]   x_pos;
	logic               text_done;
	logic               word_overflow;
	logic               last;

	int fail_count;
	int outstanding;
	int results_checked;
	int texts_closed;
	int overflow_hits;

	// sender bookkeeping
	int burst_left       = 0;
	int items_sent       = 0;
	int settings_applied = 0;
	int leftover         = 0;
	int drain_cycles     = 0;

	// receiver stall pattern
	int rx_mode      = 0;
	int rx_mode_left = 0;
	int rx_hold      = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	greedy_word_wrap_placer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.char_kind     (char_kind),
		.glyph_code    (glyph_code),
		.advance       (advance),
		.visible       (visible),
		.empty         (empty),
		.pop           (pop),
		.out_glyph     (out_glyph),
		.line_index    (line_index),
		.x_pos         (x_pos),
		.text_done     (text_done),
		.word_overflow (word_overflow),
		.last          (last)
	);

	placement_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.full            (full),
		.char_kind       (char_kind),
		.glyph_code      (glyph_code),
		.advance         (advance),
		.visible         (visible),
		.empty           (empty),
		.pop             (pop),
		.out_glyph       (out_glyph),
		.line_index      (line_index),
		.x_pos           (x_pos),
		.text_done       (text_done),
		.word_overflow   (word_overflow),
		.last            (last),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.texts_closed    (texts_closed),
		.overflow_hits   (overflow_hits)
	);

	// Receiver: picks at random between popping every cycle, coin-flip popping,
	// and long on/off stretches, and picks anew when the current mode runs out.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      <= $urandom_range(0, 2);
				rx_mode_left <= $urandom_range(32, 256);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				default: begin
					if (rx_hold == 0) begin
						pop     <= !pop;
						rx_hold <= pop ? $urandom_range(1, 20) : $urandom_range(1, 8);
					end else begin
						rx_hold <= rx_hold - 1;
					end
				end
			endcase
		end
	end

	// One register write; write enable is low again before anything follows.
	task automatic write_reg(input cfg_idx_t idx, input logic [WIDTH_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stops the sender and waits out every expected result, then the engine's
	// own tail, since spaces and newlines may leave it busy with no result.
	task automatic wait_idle();
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// New setting for a phase; upper data bits of the one-bit register are
	// junk on purpose, the block must mask them.
	task automatic apply_setting(input logic wrap, input logic [WIDTH_W-1:0] width);
		wait_idle();
		write_reg(CFG_WRAP_ENABLE, {17'($urandom), wrap});
		write_reg(CFG_LINE_WIDTH, width);
		settings_applied++;
	endtask

	// One character request. Bursts of random length, with random gaps
	// between them; now and then a long burst gives a stretch with no idling.
	task automatic send_char(input kind_t k, input logic [GLYPH_W-1:0] g,
			input logic [ADV_W-1:0] a, input logic v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		push       <= 1'b1;
		char_kind  <= k;
		glyph_code <= g;
		advance    <= a;
		visible    <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Mostly moderate advances so lines fill and wrap, with both extremes
	// and the full 12-bit range mixed in.
	function automatic logic [ADV_W-1:0] pick_advance();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 12'($urandom_range(0, 4095));
			default: return 12'($urandom_range(64, 900));
		endcase
	endfunction

	// Random text: mostly words split by spaces, some newlines and ends of
	// text, a few long words that spill past the word buffer, and a little
	// noise with every field random.
	task automatic send_random_text(input int budget);
		int start;
		int pick;
		int len;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_char(kind_t'($urandom_range(0, 3)), 16'($urandom),
					12'($urandom), 1'($urandom_range(0, 1)));
			end else if (pick < 10) begin
				send_char(KIND_END, 16'($urandom), pick_advance(), 1'($urandom_range(0, 1)));
			end else if (pick < 16) begin
				send_char(KIND_NEWLINE, 16'($urandom), pick_advance(),
					1'($urandom_range(0, 1)));
			end else if (pick < 24) begin
				send_char(KIND_SPACE, 16'($urandom), pick_advance(), 1'($urandom_range(0, 1)));
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(WORD_DEPTH - 4, WORD_DEPTH + 8)
					: $urandom_range(1, 7);
				for (int i = 0; i < len; i++)
					send_char(KIND_GLYPH, 16'($urandom), pick_advance(),
						1'($urandom_range(0, 9) != 0));
				repeat ($urandom_range(1, 2))
					send_char(KIND_SPACE, 16'($urandom), pick_advance(),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// ---- directed: wrap mode on a narrow line ----
		apply_setting(1'b1, 18'd1000);
		// space at line start is ignored; the word starts at x=0
		send_char(KIND_SPACE,   16'h0000, 12'd100,  1'b1);
		send_char(KIND_GLYPH,   16'hFFFF, 12'd300,  1'b1);
		// invisible glyph: no result, but its advance counts
		send_char(KIND_GLYPH,   16'h1234, 12'd200,  1'b0);
		send_char(KIND_SPACE,   16'hABCD, 12'd150,  1'b1);
		// 500 + 150 + 400 does not fit in 1000: wraps to the next line
		send_char(KIND_GLYPH,   16'h00AA, 12'd400,  1'b1);
		// spaces before a newline are thrown away
		send_char(KIND_SPACE,   16'h5555, 12'd4095, 1'b1);
		send_char(KIND_NEWLINE, 16'hAAAA, 12'd4095, 1'b1);
		send_char(KIND_NEWLINE, 16'h0000, 12'd0,    1'b0);
		// a word wider than the line on its own is placed and closes the line
		send_char(KIND_GLYPH,   16'h0000, 12'd4095, 1'b1);
		send_char(KIND_GLYPH,   16'h0001, 12'd10,   1'b1);
		send_char(KIND_SPACE,   16'h0000, 12'd5,    1'b0);
		send_char(KIND_GLYPH,   16'h0002, 12'd20,   1'b1);
		send_char(KIND_SPACE,   16'h0000, 12'd30,   1'b1);
		// end of text right after spaces: the spaces never break a line
		send_char(KIND_END,     16'hFFFF, 12'd4095, 1'b1);
		// empty text in wrap mode: zero lines
		send_char(KIND_END,     16'h0000, 12'd0,    1'b0);
		// a word left open when the mode switches to single line
		send_char(KIND_GLYPH,   16'h0007, 12'd50,   1'b1);

		// ---- directed: single-line mode ----
		apply_setting(1'b0, 18'd1000);
		// the word buffered in wrap mode is dropped here
		send_char(KIND_END,     16'h0000, 12'd0,    1'b0);
		send_char(KIND_GLYPH,   16'h5555, 12'd4095, 1'b1);
		send_char(KIND_SPACE,   16'h0101, 12'd7,    1'b1);
		send_char(KIND_NEWLINE, 16'h0202, 12'd9,    1'b1);
		send_char(KIND_GLYPH,   16'h0303, 12'd11,   1'b0);
		send_char(KIND_GLYPH,   16'hAAAA, 12'd13,   1'b1);
		send_char(KIND_END,     16'h0404, 12'd0,    1'b1);

		// ---- directed: zero line width ----
		apply_setting(1'b1, 18'd0);
		// zero-width words still fit; a one-unit word is overlong
		send_char(KIND_GLYPH,   16'h0010, 12'd0,    1'b1);
		send_char(KIND_SPACE,   16'h0000, 12'd0,    1'b0);
		send_char(KIND_GLYPH,   16'h0011, 12'd0,    1'b1);
		send_char(KIND_SPACE,   16'h0000, 12'd0,    1'b0);
		send_char(KIND_GLYPH,   16'h0012, 12'd1,    1'b1);
		send_char(KIND_END,     16'h0000, 12'd0,    1'b0);

		// ---- random phases, each on a fresh setting ----
		// the idle wait before each write also holds the sender off until
		// every expected result has come back
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_setting(1'b1, 18'($urandom_range(300, 3000)));
				1: apply_setting(1'b1, LINE_WIDTH_RESET);
				2: apply_setting(1'b1, 18'd0);
				3: apply_setting(1'b0, 18'($urandom));
				4: apply_setting(1'b1, 18'($urandom_range(1000, 8000)));
				default: apply_setting(1'b1, 18'($urandom_range(0, 262143)));
			endcase
			send_random_text(RANDOM_ITEMS / RANDOM_PHASES);
		end

		// ---- drain and verdict ----
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
			leftover = 1;
		end

		$display("Sent %0d character requests under %0d register settings.",
			items_sent, settings_applied);
		$display("Checked %0d results: %0d ends of text, %0d flagged overflow.",
			results_checked, texts_closed, overflow_hits);
		if (fail_count == 0 && leftover == 0) begin
			$display("** greedy_word_wrap_placer: PASSED **");
		end else begin
			$display("** greedy_word_wrap_placer: FAILED **");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("** greedy_word_wrap_placer: FAILED **");
		$finish;
	end

endmodule
